// ----- rtl/rsa_key_exponent_derivation_core_assert.svh -----
// Assertion macros shared by the key exponent derivation RTL.
`ifndef RSA_KEY_EXPONENT_DERIVATION_CORE_ASSERT_SVH
`define RSA_KEY_EXPONENT_DERIVATION_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define RKE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define RKE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RKE_ASSERT_IMPL(label, ante, cons, msg)
`define RKE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/rkexp_pkg.sv -----
// Package with the transaction types and constants of the key exponent derivation core.
package rkexp_pkg;

  // Default and fixed field widths.
  localparam int PRIME_WIDTH = 16;
  localparam int FIELD_W     = 16;
  localparam int OUT_W       = 32;

  // Input transaction: the two prime factors.
  typedef struct packed {
    logic [FIELD_W-1:0] prime_p;
    logic [FIELD_W-1:0] prime_q;
  } primes_t;

  // Output transaction: modulus and the two exponents.
  typedef struct packed {
    logic [OUT_W-1:0] modulus;
    logic [OUT_W-1:0] public_exponent;
    logic [OUT_W-1:0] private_exponent;
  } key_t;

  // Command to the serial divider.
  typedef struct packed {
    logic start;
    logic wide;
  } div_cmd_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/rkexp_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module rkexp_div #(
  parameter int NW = 2 * rkexp_pkg::PRIME_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  rkexp_pkg::div_cmd_t cmd,
  input  logic [2*NW-1:0]     dividend,
  input  logic [NW-1:0]       divisor,
  output rkexp_pkg::div_stat_t stat,
  output logic [NW-1:0]       quotient,
  output logic [NW-1:0]       remainder
);

  localparam int DW    = 2 * NW;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dsr;
  logic [NW-1:0]    rem;
  logic [NW-1:0]    den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [NW:0]   rem_shift;
  logic [NW:0]   diff;
  logic          ge;
  logic [NW-1:0] rem_next;

  // One trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    rem_shift = {rem, dsr[DW-1]};
    ge        = (rem_shift >= {1'b0, den});
    diff      = rem_shift - {1'b0, den};
    rem_next  = ge ? diff[NW-1:0] : rem_shift[NW-1:0];
  end

  // Control and datapath: the quotient bits shift in behind the dividend bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.wide ? CNT_W'(DW) : CNT_W'(NW);
        dsr  <= cmd.wide ? dividend : {dividend[NW-1:0], {NW{1'b0}}};
        rem  <= '0;
        den  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        dsr <= {dsr[DW-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dsr[NW-1:0];
  assign remainder = rem;

endmodule

// ----- rtl/rsa_key_exponent_derivation_core.sv -----
// Top level of the key exponent derivation core: product, exponent search and inverse.
// Steps: the modulus and totient products, then for each odd exponent candidate a remainder
// of the totient and Euclid steps, then t mod e, a search over multiples of t, and finally
// a product and a wide division for d.
// Throughput is one transaction at a time; synchronous rst clears the controller and divider.
`include "rsa_key_exponent_derivation_core_assert.svh"

module rsa_key_exponent_derivation_core #(
  parameter int PRIME_WIDTH = rkexp_pkg::PRIME_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               primes_valid,
  output logic               primes_ready,
  input  rkexp_pkg::primes_t primes,
  output logic               keys_valid,
  input  logic               keys_ready,
  output rkexp_pkg::key_t    keys
);

  localparam int NW    = 2 * PRIME_WIDTH;
  localparam int MCW   = $clog2(NW + 1);
  localparam int OUT_W = rkexp_pkg::OUT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_N,
    S_MUL_T,
    S_TEST,
    S_MOD_T,
    S_EUCLID,
    S_MOD_XY,
    S_TM,
    S_INV,
    S_MUL_D,
    S_DIV_D,
    S_OUT
  } state_t;

  state_t state;

  // Predecessors of the two factors.
  logic [PRIME_WIDTH-1:0] p_m1;
  logic [PRIME_WIDTH-1:0] q_m1;

  // Key quantities.
  logic [NW-1:0] modulus;
  logic [NW-1:0] totient;
  logic [NW-1:0] cand;
  logic [NW-1:0] pub_e;
  logic [NW-1:0] priv_d;

  // Euclid and inverse search registers.
  logic [NW-1:0] gx;
  logic [NW-1:0] gy;
  logic [NW-1:0] t_mod_e;
  logic [NW-1:0] acc;
  logic [NW-1:0] idx;

  // Shift-and-add multiplier.
  logic [NW-1:0]   mul_a;
  logic [NW-1:0]   mul_b;
  logic [2*NW-1:0] prod;
  logic [MCW-1:0]  mul_cnt;
  logic [NW:0]     mul_hi_sum;

  // Divider interface.
  rkexp_pkg::div_cmd_t  div_cmd;
  rkexp_pkg::div_stat_t div_stat;
  logic [2*NW-1:0]      dv_num;
  logic [NW-1:0]        dv_den;
  logic [NW-1:0]        div_quo;
  logic [NW-1:0]        div_rem;

  // Inverse search step: next multiple of t reduced modulo e.
  logic [NW:0]   acc_sum;
  logic [NW:0]   acc_red;
  logic [NW-1:0] acc_next;

  logic accept;

  assign primes_ready = (state == S_IDLE);
  assign accept       = primes_valid && primes_ready;

  // One multiplier bit per cycle, least significant first.
  always_comb begin
    mul_hi_sum = {1'b0, prod[2*NW-1:NW]} + (mul_b[0] ? {1'b0, mul_a} : {(NW+1){1'b0}});
  end

  // Modular accumulation for the inverse search.
  always_comb begin
    acc_sum  = {1'b0, acc} + {1'b0, t_mod_e};
    acc_red  = acc_sum - {1'b0, pub_e};
    acc_next = (acc_sum >= {1'b0, pub_e}) ? acc_red[NW-1:0] : acc_sum[NW-1:0];
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      keys_valid    <= 1'b0;
      div_cmd.start <= 1'b0;
      div_cmd.wide  <= 1'b0;
    end else begin
      // The divider start is a single-cycle pulse; no state that follows a start raises it.
      if (div_cmd.start) begin
        div_cmd.start <= 1'b0;
      end
      // A taken result is cleared unless a new one is loaded in the same cycle.
      if (keys_valid && keys_ready && state != S_OUT) begin
        keys_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mul_a   <= NW'(primes.prime_p[PRIME_WIDTH-1:0]);
            mul_b   <= NW'(primes.prime_q[PRIME_WIDTH-1:0]);
            p_m1    <= (primes.prime_p[PRIME_WIDTH-1:0] != '0) ?
                       primes.prime_p[PRIME_WIDTH-1:0] - PRIME_WIDTH'(1) : '0;
            q_m1    <= (primes.prime_q[PRIME_WIDTH-1:0] != '0) ?
                       primes.prime_q[PRIME_WIDTH-1:0] - PRIME_WIDTH'(1) : '0;
            prod    <= '0;
            mul_cnt <= MCW'(NW);
            state   <= S_MUL_N;
          end
        end
        S_MUL_N: begin
          if (mul_cnt != '0) begin
            prod    <= {mul_hi_sum, prod[NW-1:1]};
            mul_b   <= mul_b >> 1;
            mul_cnt <= mul_cnt - MCW'(1);
          end else begin
            modulus <= prod[NW-1:0];
            mul_a   <= NW'(p_m1);
            mul_b   <= NW'(q_m1);
            prod    <= '0;
            mul_cnt <= MCW'(NW);
            state   <= S_MUL_T;
          end
        end
        S_MUL_T: begin
          if (mul_cnt != '0) begin
            prod    <= {mul_hi_sum, prod[NW-1:1]};
            mul_b   <= mul_b >> 1;
            mul_cnt <= mul_cnt - MCW'(1);
          end else begin
            totient <= prod[NW-1:0];
            cand    <= NW'(3);
            state   <= S_TEST;
          end
        end
        S_TEST: begin
          // Candidates run over odd values from three up to below the totient.
          if (cand < totient) begin
            dv_num        <= (2*NW)'(totient);
            dv_den        <= cand;
            div_cmd.start <= 1'b1;
            div_cmd.wide  <= 1'b0;
            state         <= S_MOD_T;
          end else begin
            pub_e  <= NW'(1);
            priv_d <= totient + NW'(1);
            state  <= S_OUT;
          end
        end
        S_MOD_T: begin
          if (div_stat.done) begin
            gx    <= cand;
            gy    <= div_rem;
            state <= S_EUCLID;
          end
        end
        S_EUCLID: begin
          if (gy == '0) begin
            if (gx == NW'(1)) begin
              // Coprime candidate found: reduce the totient modulo it.
              pub_e         <= cand;
              dv_num        <= (2*NW)'(totient);
              dv_den        <= cand;
              div_cmd.start <= 1'b1;
              div_cmd.wide  <= 1'b0;
              state         <= S_TM;
            end else begin
              cand  <= cand + NW'(2);
              state <= S_TEST;
            end
          end else begin
            dv_num        <= (2*NW)'(gx);
            dv_den        <= gy;
            div_cmd.start <= 1'b1;
            div_cmd.wide  <= 1'b0;
            state         <= S_MOD_XY;
          end
        end
        S_MOD_XY: begin
          if (div_stat.done) begin
            gx    <= gy;
            gy    <= div_rem;
            state <= S_EUCLID;
          end
        end
        S_TM: begin
          if (div_stat.done) begin
            t_mod_e <= div_rem;
            acc     <= div_rem;
            idx     <= NW'(1);
            state   <= S_INV;
          end
        end
        S_INV: begin
          // Looking for the first multiple i*t that is one short of a multiple of e.
          if (acc == pub_e - NW'(1)) begin
            mul_a   <= totient;
            mul_b   <= idx;
            prod    <= '0;
            mul_cnt <= MCW'(NW);
            state   <= S_MUL_D;
          end else if (idx == pub_e) begin
            priv_d <= '0;
            state  <= S_OUT;
          end else begin
            idx <= idx + NW'(1);
            acc <= acc_next;
          end
        end
        S_MUL_D: begin
          if (mul_cnt != '0) begin
            prod    <= {mul_hi_sum, prod[NW-1:1]};
            mul_b   <= mul_b >> 1;
            mul_cnt <= mul_cnt - MCW'(1);
          end else begin
            dv_num        <= prod + (2*NW)'(1);
            dv_den        <= pub_e;
            div_cmd.start <= 1'b1;
            div_cmd.wide  <= 1'b1;
            state         <= S_DIV_D;
          end
        end
        S_DIV_D: begin
          if (div_stat.done) begin
            priv_d <= div_quo;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          // The result waits here until the output register is free.
          if (!keys_valid || keys_ready) begin
            keys.modulus          <= OUT_W'(modulus);
            keys.public_exponent  <= OUT_W'(pub_e);
            keys.private_exponent <= OUT_W'(priv_d);
            keys_valid            <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Shared serial divider for the remainders and the final quotient.
  rkexp_div #(
    .NW (NW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .cmd       (div_cmd),
    .dividend  (dv_num),
    .divisor   (dv_den),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Checks on the sequencer and the divider working together.
  `RKE_ASSERT_IMPL(a_idle_div_quiet, state == S_IDLE, !div_stat.busy && !div_stat.done, "divider active while the sequencer is idle")
  `RKE_ASSERT_NEXT(a_accept_starts, accept, state == S_MUL_N, "accepted transaction did not start the modulus product")
  `RKE_ASSERT_IMPL(a_exponent_odd, state == S_INV, pub_e[0] && pub_e >= NW'(3), "inverse search with an even or small exponent")
  `RKE_ASSERT_NEXT(a_result_loaded, state == S_OUT && (!keys_valid || keys_ready), keys_valid && state == S_IDLE, "result not loaded into the output register")

endmodule

// ----- test/tb_rsa_key_exponent_derivation_core.sv -----
// Self-checking testbench for the key exponent derivation core, with a scoreboard class.
module tb_rsa_key_exponent_derivation_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 300;
  localparam int CALM_TAIL    = 60;
  localparam int STALL_LIMIT  = 25000;
  localparam int SETTLE_WAIT  = 300;

  // Scoreboard: works out the expected key of every accepted pair of factors
  // and compares each returned key with the oldest one still waiting.
  class key_scoreboard;
    rkexp_pkg::key_t pending_keys[$];
    int unsigned     errors;
    int unsigned     pairs_seen;
    int unsigned     keys_seen;
    int unsigned     fallbacks;
    logic [31:0]     widest_exponent;

    function new();
      errors          = 0;
      pairs_seen      = 0;
      keys_seen       = 0;
      fallbacks       = 0;
      widest_exponent = '0;
    endfunction

    static function logic [31:0] gcd32(logic [31:0] x, logic [31:0] y);
      logic [31:0] r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    // Modulus, smallest coprime odd exponent and its inverse by the search rule.
    static function rkexp_pkg::key_t derive_key(rkexp_pkg::primes_t f);
      logic [15:0]     mask;
      logic [31:0]     p, q, pm, qm, tot, e, d, c;
      logic [63:0]     v;
      rkexp_pkg::key_t k;
      mask = 16'((32'd1 << rkexp_pkg::PRIME_WIDTH) - 1);
      p    = 32'(f.prime_p & mask);
      q    = 32'(f.prime_q & mask);
      // A factor of zero must not wrap when one is taken away.
      pm   = (p > 0) ? p - 1 : 32'd0;
      qm   = (q > 0) ? q - 1 : 32'd0;
      tot  = pm * qm;
      e    = 32'd1;
      d    = 32'd0;
      for (c = 32'd3; c < tot; c += 2) begin
        if (gcd32(tot, c) == 32'd1) begin
          e = c;
          break;
        end
      end
      if (e == 32'd1) begin
        d = tot + 1;
      end else begin
        for (longint unsigned i = 1; i <= e; i++) begin
          v = i * tot + 1;
          if (v % e == 0) begin
            d = 32'(v / e);
            break;
          end
        end
      end
      k.modulus          = p * q;
      k.public_exponent  = e;
      k.private_exponent = d;
      return k;
    endfunction

    function void note_primes(rkexp_pkg::primes_t f);
      rkexp_pkg::key_t k;
      k = derive_key(f);
      pending_keys.push_back(k);
      pairs_seen++;
      if (k.public_exponent == 32'd1) fallbacks++;
      if (k.public_exponent > widest_exponent) widest_exponent = k.public_exponent;
    endfunction

    function void check_key(rkexp_pkg::key_t got);
      rkexp_pkg::key_t want;
      keys_seen++;
      if (pending_keys.size() == 0) begin
        $error("key transaction with no pair of factors outstanding: %h", got);
        errors++;
        return;
      end
      want = pending_keys.pop_front();
      if (got.modulus !== want.modulus) begin
        $error("modulus: expected %0d, got %0d", want.modulus, got.modulus);
        errors++;
      end
      if (got.public_exponent !== want.public_exponent) begin
        $error("public_exponent: expected %0d, got %0d",
               want.public_exponent, got.public_exponent);
        errors++;
      end
      if (got.private_exponent !== want.private_exponent) begin
        $error("private_exponent: expected %0d, got %0d",
               want.private_exponent, got.private_exponent);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_keys.size();
    endfunction
  endclass

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               primes_valid = 1'b0;
  logic               primes_ready;
  rkexp_pkg::primes_t primes       = '0;
  logic               keys_valid;
  logic               keys_ready   = 1'b0;
  rkexp_pkg::key_t    keys;

  key_scoreboard sb = new();

  bit          idling_on  = 1'b1;
  int unsigned sink_stall = 0;
  int unsigned quiet_cycles = 0;

  rsa_key_exponent_derivation_core u_top (
    .clk          (clk),
    .rst          (rst),
    .primes_valid (primes_valid),
    .primes_ready (primes_ready),
    .primes       (primes),
    .keys_valid   (keys_valid),
    .keys_ready   (keys_ready),
    .keys         (keys)
  );

  // Clock generation.
  always #4 clk = ~clk;

  // Observe both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (primes_valid && primes_ready) sb.note_primes(primes);
      if (keys_valid && keys_ready) sb.check_key(keys);
    end
  end

  // Result side: ready drops in random bursts while idling is enabled.
  always @(negedge clk) begin
    if (rst) begin
      keys_ready <= 1'b0;
    end else if (!idling_on) begin
      keys_ready <= 1'b1;
    end else if (sink_stall > 0) begin
      keys_ready <= 1'b0;
      sink_stall--;
    end else if ($urandom_range(0, 4) == 0) begin
      keys_ready <= 1'b0;
      sink_stall = $urandom_range(1, 6) - 1;
    end else begin
      keys_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (rst || (primes_valid && primes_ready) || (keys_valid && keys_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("** rsa_key_exponent_derivation_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit is_prime(int unsigned x);
    if (x < 2) return 1'b0;
    for (int unsigned k = 2; k * k <= x; k++) begin
      if (x % k == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Smallest prime at or above x, wrapping round to two.
  function automatic logic [15:0] prime_from(int unsigned x);
    while (!is_prime(x)) begin
      x++;
      if (x > 65535) x = 2;
    end
    return 16'(x);
  endfunction

  // Prime of a random bit length.
  function automatic logic [15:0] random_prime();
    int unsigned w;
    w = $urandom_range(2, 16);
    return prime_from($urandom_range(2, (1 << w) - 1));
  endfunction

  // One plus a product of small primes, so the totient rules out many small exponents.
  function automatic logic [15:0] smooth_plus_one();
    int unsigned odd_primes[9] = '{3, 5, 7, 11, 13, 17, 19, 23, 29};
    int unsigned v;
    v = 2;
    foreach (odd_primes[k]) begin
      if ($urandom_range(0, 1) == 1 && v * odd_primes[k] <= 65534) v = v * odd_primes[k];
    end
    return 16'(v + 1);
  endfunction

  // Present one pair of factors and hold it until accepted.
  task automatic send_pair(logic [15:0] a, logic [15:0] b);
    @(negedge clk);
    primes_valid   <= 1'b1;
    primes.prime_p <= a;
    primes.prime_q <= b;
    do @(posedge clk); while (!primes_ready);
  endtask

  task automatic hold_off_sender(int unsigned cycles);
    @(negedge clk);
    primes_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stop sending and wait for every outstanding key to come back.
  task automatic drain_keys();
    @(negedge clk);
    primes_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] a, b;
    int unsigned kind;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pairs: zero and one factors, tiny totients, crowded totients, extremes.
    send_pair(16'd0, 16'd0);
    send_pair(16'd0, 16'd65535);
    send_pair(16'd1, 16'd7);
    send_pair(16'd65535, 16'd1);
    send_pair(16'd2, 16'd2);
    send_pair(16'd2, 16'd3);
    send_pair(16'd3, 16'd2);
    send_pair(16'd2, 16'd5);
    send_pair(16'd3, 16'd3);
    send_pair(16'd4, 16'd4);
    send_pair(16'd3, 16'd5);
    send_pair(16'd5, 16'd7);
    send_pair(16'd7, 16'd11);
    send_pair(16'd61, 16'd53);
    send_pair(16'd211, 16'd287);
    send_pair(16'd30031, 16'd14859);
    send_pair(16'd65521, 16'd65519);
    send_pair(16'd65535, 16'd65535);
    send_pair(16'd65535, 16'd65534);
    send_pair(16'd43690, 16'd21845);
    send_pair(16'd21845, 16'd43690);
    send_pair(16'd32768, 16'd32767);
    drain_keys();

    // Random pairs, mostly primes, in stretches with and without idling.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 25 == 0) idling_on = ($urandom_range(0, 3) != 0);
      if (n >= RANDOM_ITEMS - CALM_TAIL) idling_on = 1'b0;
      if (n == RANDOM_ITEMS / 2) drain_keys();

      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        a = random_prime();
        b = random_prime();
      end else if (kind <= 7) begin
        a = 16'($urandom);
        b = 16'($urandom);
      end else if (kind == 8) begin
        a = 16'($urandom_range(0, 7));
        b = 16'($urandom_range(0, 7));
      end else begin
        a = smooth_plus_one();
        b = ($urandom_range(0, 1) == 1) ? smooth_plus_one() : random_prime();
      end

      if (idling_on && $urandom_range(0, 3) == 0) hold_off_sender($urandom_range(1, 6));
      send_pair(a, b);
    end
    drain_keys();
    repeat (SETTLE_WAIT) @(posedge clk);

    if (sb.outstanding() != 0) begin
      $error("%0d keys never returned", sb.outstanding());
      sb.errors++;
    end

    $display("Run covered %0d factor pairs and %0d returned keys.", sb.pairs_seen, sb.keys_seen);
    $display("Fallback exponent taken %0d times; largest public exponent %0d.",
             sb.fallbacks, sb.widest_exponent);
    if (sb.errors == 0) begin
      $display("** rsa_key_exponent_derivation_core: PASSED **");
    end else begin
      $display("** rsa_key_exponent_derivation_core: FAILED **");
    end
    $finish;
  end

endmodule
